>>> hw/rtl/rpn_pkg.sv
// Shared types, field widths and command/status codes for the RPN stack calculator.
// No dependencies; used by rpn_cell, rpn_divider and rpn_stack_calculator.
`default_nettype none

package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int MODE_W          = 3;
  localparam int STATUS_W        = 3;
  localparam int COUNT_OUT_W     = 5;
  localparam int STACK_DEPTH_DEF = 16;

  // command codes
  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIV   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POP   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ONE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // per-cell move command
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_ABOVE,
    CELL_FROM_BELOW,
    CELL_LOAD
  } cell_op_t;

endpackage

`default_nettype wire

>>> hw/rtl/rpn_cell.sv
// One stack entry of the shift-register stack; moves data to/from its neighbors.
// Depends on rpn_pkg.
`default_nettype none

module rpn_cell (
  input  wire logic                             clk,
  input  wire rpn_pkg::cell_op_t                op,
  input  wire logic signed [rpn_pkg::DATA_W-1:0] above_d,
  input  wire logic signed [rpn_pkg::DATA_W-1:0] below_d,
  input  wire logic signed [rpn_pkg::DATA_W-1:0] load_d,
  output logic signed [rpn_pkg::DATA_W-1:0]      q
);

  logic signed [rpn_pkg::DATA_W-1:0] data_r;
  logic signed [rpn_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    case (op)
      rpn_pkg::CELL_FROM_ABOVE: data_nxt = above_d;
      rpn_pkg::CELL_FROM_BELOW: data_nxt = below_d;
      rpn_pkg::CELL_LOAD:       data_nxt = load_d;
      default:                  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

>>> hw/rtl/rpn_divider.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg.
`default_nettype none

module rpn_divider (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [rpn_pkg::DATA_W-1:0] num,
  input  wire logic signed [rpn_pkg::DATA_W-1:0] den,
  output logic                                   done,
  output logic signed [rpn_pkg::DATA_W-1:0]      quotient
);

  localparam int W   = rpn_pkg::DATA_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dmag_r, dmag_nxt;
  logic             neg_r, neg_nxt;

  logic [W:0]       shifted;
  logic [W:0]       trial;

  assign shifted = {rem_r, quo_r[W-1]};
  assign trial   = shifted - {1'b0, dmag_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W);
      rem_nxt  = '0;
      quo_nxt  = num[W-1] ? (W'(0) - W'(num)) : W'(num);
      dmag_nxt = den[W-1] ? (W'(0) - W'(den)) : W'(den);
      neg_nxt  = num[W-1] ^ den[W-1];
    end else if (busy_r) begin
      // restoring step: keep the trial difference when it does not go negative
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? $signed(W'(0) - quo_r) : $signed(quo_r);

endmodule

`default_nettype wire

>>> hw/rtl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: command sequencer, ALU and the cell-chain stack.
// Depends on rpn_pkg, rpn_cell and rpn_divider.
//
//   channel | ports                                       | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid, in_ready, in_mode, in_push_value  | command in
//   out     | out_valid, out_ready, out_status,           | result out
//           | out_result_value, out_entry_count           |
//
// One command at a time: push, pop, clear, add and subtract go through S_DECIDE and S_DONE;
// multiply adds S_MUL, where the product is registered; divide waits in S_DIV on the
// one-bit-per-cycle divider over 32 quotient bits.
// Reset clears the entry count, sequencer and result valid; stack cells keep their data.
// A stalled result is held in the output register; the next command can already
// transfer in, and its result waits in the final state until the register frees.
`default_nettype none

module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [rpn_pkg::MODE_W-1:0]             in_mode,
  input  wire logic signed [rpn_pkg::DATA_W-1:0]      in_push_value,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [rpn_pkg::STATUS_W-1:0]                out_status,
  output logic signed [rpn_pkg::DATA_W-1:0]           out_result_value,
  output logic [rpn_pkg::COUNT_OUT_W-1:0]             out_entry_count
);

  localparam int W    = rpn_pkg::DATA_W;
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int OW   = rpn_pkg::COUNT_OUT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic [rpn_pkg::MODE_W-1:0]        mode_r;
  logic signed [W-1:0]               val_r;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [rpn_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic signed [W-1:0]               res_r, res_nxt;

  logic                              out_valid_r;
  logic [rpn_pkg::STATUS_W-1:0]      out_status_r;
  logic signed [W-1:0]               out_result_r;
  logic [CW-1:0]                     out_count_r;

  logic signed [W-1:0]               cell_q [STACK_DEPTH];
  rpn_pkg::cell_op_t                 head_op, rest_op;
  logic signed [W-1:0]               top_d, next_d;
  logic [W-1:0]                      product;

  logic                              div_start, div_done;
  logic signed [W-1:0]               div_q;

  logic                              in_xfer, out_free, commit;
  logic                              have_two;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == S_DONE) && out_free;

  // top of stack lives in cell 0, the entry below it in cell 1
  assign top_d    = cell_q[0];
  assign next_d   = cell_q[1];
  assign have_two = (count_r >= CW'(2));
  // keep only the low word of the product
  assign product  = $unsigned(next_d) * $unsigned(top_d);

  assign div_start = (state_r == S_DECIDE) && (mode_r == rpn_pkg::MODE_DIV) &&
                     have_two && (top_d != '0);

  rpn_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (next_d),
    .den      (top_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // decide the outcome, then wait for the multi-cycle units where needed
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        status_nxt = rpn_pkg::ST_OK;
        res_nxt    = '0;
        state_nxt  = S_DONE;
        unique case (mode_r) inside
          rpn_pkg::MODE_PUSH: begin
            if (count_r == CW'(STACK_DEPTH)) status_nxt = rpn_pkg::ST_FULL;
            else res_nxt = val_r;
          end
          rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL,
          rpn_pkg::MODE_DIV: begin
            if (count_r == '0) begin
              status_nxt = rpn_pkg::ST_EMPTY;
            end else if (count_r == CW'(1)) begin
              status_nxt = rpn_pkg::ST_ONE;
            end else begin
              case (mode_r)
                rpn_pkg::MODE_ADD: res_nxt = next_d + top_d;
                rpn_pkg::MODE_SUB: res_nxt = next_d - top_d;
                rpn_pkg::MODE_MUL: state_nxt = S_MUL;
                default: begin
                  if (top_d == '0) status_nxt = rpn_pkg::ST_DIVZERO;
                  else state_nxt = S_DIV;
                end
              endcase
            end
          end
          rpn_pkg::MODE_POP: begin
            if (count_r == '0) status_nxt = rpn_pkg::ST_EMPTY;
            else res_nxt = top_d;
          end
          default: ;
        endcase
      end
      S_MUL: begin
        res_nxt   = $signed(product);
        state_nxt = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = div_q;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // stack moves and new entry count, applied when the result commits
  always_comb begin
    head_op   = rpn_pkg::CELL_HOLD;
    rest_op   = rpn_pkg::CELL_HOLD;
    count_nxt = count_r;
    if (commit && status_r == rpn_pkg::ST_OK) begin
      unique case (mode_r) inside
        rpn_pkg::MODE_PUSH: begin
          head_op   = rpn_pkg::CELL_FROM_ABOVE;
          rest_op   = rpn_pkg::CELL_FROM_ABOVE;
          count_nxt = count_r + CW'(1);
        end
        rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL,
        rpn_pkg::MODE_DIV: begin
          head_op   = rpn_pkg::CELL_LOAD;
          rest_op   = rpn_pkg::CELL_FROM_BELOW;
          count_nxt = count_r - CW'(1);
        end
        rpn_pkg::MODE_POP: begin
          head_op   = rpn_pkg::CELL_FROM_BELOW;
          rest_op   = rpn_pkg::CELL_FROM_BELOW;
          count_nxt = count_r - CW'(1);
        end
        rpn_pkg::MODE_CLEAR: count_nxt = '0;
        default: ;
      endcase
    end
  end

  // chain of stack cells; cell 0 takes pushes from the command register
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [W-1:0] above_d, below_d;
    if (i == 0) begin : g_head
      assign above_d = val_r;
    end else begin : g_body
      assign above_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below_d = '0;
    end else begin : g_link
      assign below_d = cell_q[i+1];
    end
    rpn_cell u_cell (
      .clk     (clk),
      .op      ((i == 0) ? head_op : rest_op),
      .above_d (above_d),
      .below_d (below_d),
      .load_d  (res_r),
      .q       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (in_xfer) begin
      mode_r <= in_mode;
      val_r  <= in_push_value;
    end
    status_r <= status_nxt;
    res_r    <= res_nxt;
    if (commit) begin
      out_status_r <= status_r;
      out_result_r <= (status_r == rpn_pkg::ST_OK) ? res_r : '0;
      out_count_r  <= count_nxt;
    end
  end

  // entry count goes out modulo 32
  logic [CW+OW-1:0] count_ext;
  assign count_ext = {{OW{1'b0}}, out_count_r};

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_result_r;
  assign out_entry_count  = count_ext[OW-1:0];

endmodule

`default_nettype wire
